[src/itob_pkg.sv]
// Shared types and constants for the integer-to-base-digits converter.
`default_nettype none
package itob_pkg;

  localparam int VALUE_WIDTH_DEF = 32;
  localparam int MAX_BASE_DEF    = 16;
  localparam int MAX_DIGITS_DEF  = 32;

  localparam int DIGIT_W    = 4;
  localparam int CHAR_W     = 8;
  localparam int BASE_W     = 5;
  localparam int CHARS_W    = 64;
  localparam int CFG_IDX_W  = 2;
  localparam int CHUNK_BITS = 8;

  localparam logic [BASE_W-1:0]  BASE_RESET       = 5'd10;
  localparam logic [CHARS_W-1:0] CHARS_LOW_RESET  = 64'h3736353433323130;
  localparam logic [CHARS_W-1:0] CHARS_HIGH_RESET = 64'h4645444342413938;
  localparam logic [CHAR_W-1:0]  MINUS_CHAR       = 8'h2D;

  localparam logic [CFG_IDX_W-1:0] REG_DIGIT_BASE       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIGIT_CHARS_LOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIGIT_CHARS_HIGH = 2'd2;

  typedef struct packed {
    logic load;
    logic div_first;
    logic div_step;
    logic store;
    logic emit_sign;
    logic rd;
    logic emit_digit;
  } itob_cmd_t;

  typedef struct packed {
    logic neg;
    logic q_zero;
    logic cnt_last;
    logic cnt_one;
    logic out_free;
  } itob_status_t;

endpackage
`default_nettype wire

[src/integer_to_base_digits.sv]
// Top level of the signed integer to base-N text converter.
// Converts each signed input word into its text in a base of 2 to 16 and streams it out
// one character per transaction, most significant digit first, with '-' ahead of a
// negative value and tlast on the final character; zero gives one digit-0 character.
// Digits come from an 8-bit-per-chunk long divider, and each digit character then passes
// through the registered digit store read. The sign step is taken whether or not a '-'
// goes out. Holding off the output while a character waits stalls the converter. One word
// is converted at a time; a new word is taken while the last character still waits in the
// output register. Configuration is to be written only while the block is idle; the block
// itself does not enforce this.
`default_nettype none
module integer_to_base_digits #(
  parameter int VALUE_WIDTH = itob_pkg::VALUE_WIDTH_DEF,
  parameter int MAX_BASE    = itob_pkg::MAX_BASE_DEF,
  parameter int MAX_DIGITS  = itob_pkg::MAX_DIGITS_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_we,
  input  wire logic [itob_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [itob_pkg::CHARS_W-1:0]         cfg_data,
  input  wire logic                                 s_axis_tvalid,
  output logic                                      s_axis_tready,
  // fields from bit 0: value
  input  wire logic [((VALUE_WIDTH+7)/8)*8-1:0]     s_axis_tdata,
  output logic                                      m_axis_tvalid,
  input  wire logic                                 m_axis_tready,
  // fields from bit 0: out_char
  output logic [itob_pkg::CHAR_W-1:0]               m_axis_tdata,
  output logic                                      m_axis_tlast
);
  import itob_pkg::*;

  itob_cmd_t    cmd;
  itob_status_t sts;

  itob_ctrl #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(s_axis_tvalid),
    .in_ready(s_axis_tready),
    .sts     (sts),
    .cmd     (cmd)
  );

  itob_dp #(
    .VALUE_WIDTH(VALUE_WIDTH),
    .MAX_BASE   (MAX_BASE),
    .MAX_DIGITS (MAX_DIGITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .value    (s_axis_tdata[VALUE_WIDTH-1:0]),
    .cmd      (cmd),
    .sts      (sts),
    .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready),
    .out_char (m_axis_tdata),
    .out_last (m_axis_tlast)
  );

endmodule
`default_nettype wire

[src/itob_ctrl.sv]
// Controller state machine: sequences division, digit storage and character output.
`default_nettype none
module itob_ctrl #(
  parameter int VALUE_WIDTH = itob_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire itob_pkg::itob_status_t sts,
  output itob_pkg::itob_cmd_t       cmd
);
  import itob_pkg::*;

  localparam int CHUNKS  = (VALUE_WIDTH + CHUNK_BITS - 1) / CHUNK_BITS;
  localparam int CHUNK_CW = $clog2(CHUNKS + 1);
  localparam logic [CHUNK_CW-1:0] CHUNK_LAST = CHUNK_CW'(CHUNKS - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_STORE,
    S_SIGN,
    S_READ,
    S_EMIT
  } state_t;

  state_t state;
  logic [CHUNK_CW-1:0] chunk_cnt;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd            = '0;
    cmd.load       = in_ready && in_valid;
    cmd.div_step   = (state == S_DIV);
    cmd.div_first  = (state == S_DIV) && (chunk_cnt == '0);
    cmd.store      = (state == S_STORE);
    cmd.emit_sign  = (state == S_SIGN) && sts.neg && sts.out_free;
    cmd.rd         = (state == S_READ);
    cmd.emit_digit = (state == S_EMIT) && sts.out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      chunk_cnt <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          chunk_cnt <= '0;
          if (in_valid) state <= S_DIV;
        end
        S_DIV: begin
          if (chunk_cnt == CHUNK_LAST) begin
            chunk_cnt <= '0;
            state     <= S_STORE;
          end else begin
            chunk_cnt <= chunk_cnt + 1'b1;
          end
        end
        S_STORE: begin
          // stop once the quotient is exhausted or the store is full
          if (sts.q_zero || sts.cnt_last) state <= S_SIGN;
          else state <= S_DIV;
        end
        S_SIGN: begin
          if (!sts.neg || sts.out_free) state <= S_READ;
        end
        S_READ: begin
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (sts.out_free) begin
            if (sts.cnt_one) state <= S_IDLE;
            else state <= S_READ;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

[src/itob_dp.sv]
// Datapath: configuration registers, digit divider, digit store and output register.
`default_nettype none
module itob_dp #(
  parameter int VALUE_WIDTH = itob_pkg::VALUE_WIDTH_DEF,
  parameter int MAX_BASE    = itob_pkg::MAX_BASE_DEF,
  parameter int MAX_DIGITS  = itob_pkg::MAX_DIGITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [itob_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [itob_pkg::CHARS_W-1:0]      cfg_data,
  input  wire logic [VALUE_WIDTH-1:0]            value,
  input  wire itob_pkg::itob_cmd_t               cmd,
  output itob_pkg::itob_status_t                 sts,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [itob_pkg::CHAR_W-1:0]            out_char,
  output logic                                   out_last
);
  import itob_pkg::*;

  localparam int CHUNKS = (VALUE_WIDTH + CHUNK_BITS - 1) / CHUNK_BITS;
  localparam int PW     = CHUNKS * CHUNK_BITS;
  localparam int CNT_W  = $clog2(MAX_DIGITS + 1);
  localparam int IDX_W  = $clog2(MAX_DIGITS);

  // configuration
  logic [BASE_W-1:0]  digit_base;
  logic [CHARS_W-1:0] digit_chars_low;
  logic [CHARS_W-1:0] digit_chars_high;

  always_ff @(posedge clk) begin
    if (rst) begin
      digit_base       <= BASE_RESET;
      digit_chars_low  <= CHARS_LOW_RESET;
      digit_chars_high <= CHARS_HIGH_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DIGIT_BASE:       digit_base       <= cfg_data[BASE_W-1:0];
        REG_DIGIT_CHARS_LOW:  digit_chars_low  <= cfg_data;
        REG_DIGIT_CHARS_HIGH: digit_chars_high <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [BASE_W-1:0] base_eff;
  always_comb begin
    if (digit_base < BASE_W'(2)) base_eff = BASE_W'(2);
    else if (digit_base > BASE_W'(MAX_BASE)) base_eff = BASE_W'(MAX_BASE);
    else base_eff = digit_base;
  end

  // divider: quotient register rotates one chunk per cycle
  logic [PW-1:0]         quotient_reg;
  logic [DIGIT_W-1:0]    rem;
  logic                  negative_flag;
  logic [VALUE_WIDTH-1:0] magnitude;
  logic [DIGIT_W-1:0]    r;
  logic [BASE_W-1:0]     r5;
  logic [CHUNK_BITS-1:0] qbits;
  logic [CHUNK_BITS-1:0] top_bits;

  assign magnitude = value[VALUE_WIDTH-1] ? (~value + 1'b1) : value;
  assign top_bits  = quotient_reg[PW-1 -: CHUNK_BITS];

  always_comb begin
    r     = cmd.div_first ? '0 : rem;
    r5    = '0;
    qbits = '0;
    for (int i = 0; i < CHUNK_BITS; i++) begin
      r5 = {r, top_bits[CHUNK_BITS-1-i]};
      if (r5 >= base_eff) begin
        r5 = r5 - base_eff;
        qbits[CHUNK_BITS-1-i] = 1'b1;
      end
      r = r5[DIGIT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      quotient_reg  <= '0;
      negative_flag <= 1'b0;
    end else if (cmd.load) begin
      quotient_reg  <= PW'(magnitude);
      negative_flag <= value[VALUE_WIDTH-1];
    end else if (cmd.div_step) begin
      quotient_reg  <= (quotient_reg << CHUNK_BITS) | PW'(qbits);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_step) rem <= r;
  end

  // digit store and count
  logic [DIGIT_W-1:0] digit_store [MAX_DIGITS];
  logic [CNT_W-1:0]   digit_count;
  logic [CNT_W-1:0]   rd_pos;
  logic [DIGIT_W-1:0] rd_digit;

  assign rd_pos = digit_count - 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      digit_count <= '0;
    end else if (cmd.load) begin
      digit_count <= '0;
    end else if (cmd.store) begin
      digit_count <= digit_count + 1'b1;
    end else if (cmd.emit_digit) begin
      digit_count <= digit_count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store) digit_store[digit_count[IDX_W-1:0]] <= rem;
    if (cmd.rd) rd_digit <= digit_store[rd_pos[IDX_W-1:0]];
  end

  // output register
  logic [CHARS_W*2-1:0] char_table;
  logic [CHAR_W-1:0]    digit_char;

  assign char_table = {digit_chars_high, digit_chars_low};
  assign digit_char = char_table[rd_digit*CHAR_W +: CHAR_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_sign || cmd.emit_digit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_sign) begin
      out_char <= MINUS_CHAR;
      out_last <= 1'b0;
    end else if (cmd.emit_digit) begin
      out_char <= digit_char;
      out_last <= (digit_count == CNT_W'(1));
    end
  end

  always_comb begin
    sts.neg      = negative_flag;
    sts.q_zero   = (quotient_reg == '0);
    sts.cnt_last = (digit_count == CNT_W'(MAX_DIGITS - 1));
    sts.cnt_one  = (digit_count == CNT_W'(1));
    sts.out_free = !out_valid || out_ready;
  end

endmodule
`default_nettype wire

[tb/sv/integer_to_base_digits_test.sv]
// Self-checking testbench for the integer-to-base-digits text converter.
`default_nettype none
module integer_to_base_digits_test;
  import itob_pkg::*;

  localparam int VW          = VALUE_WIDTH_DEF;
  localparam int TDATA_W     = ((VW + 7) / 8) * 8;
  localparam int MAXD        = MAX_DIGITS_DEF;
  localparam int STALL_LIMIT = 6000;
  localparam int LONG_HOLD   = 400;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam logic [BASE_W-1:0] EXTREME_BASES [6] = '{5'd0, 5'd1, 5'd2, 5'd16, 5'd17, 5'd31};

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } text_char_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CHARS_W-1:0]   cfg_data = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [TDATA_W-1:0]   s_axis_tdata = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [CHAR_W-1:0]    m_axis_tdata;
  logic                 m_axis_tlast;

  // Mirror of the converter's settings
  logic [BASE_W-1:0]  base_setting = BASE_RESET;
  logic [CHARS_W-1:0] glyphs_low   = CHARS_LOW_RESET;
  logic [CHARS_W-1:0] glyphs_high  = CHARS_HIGH_RESET;

  logic [VW-1:0] pending_values [$];
  text_char_t    expected_chars [$];

  logic          offering = 1'b0;
  logic [VW-1:0] word_on_bus = '0;
  int            send_gap = 0;
  int            stall_left = 0;
  int            long_hold_req = 0;
  logic          send_idle_on = 1'b1;
  logic          recv_idle_on = 1'b1;

  int            values_sent = 0;
  int            chars_checked = 0;
  int            mismatches = 0;
  int            stray_chars = 0;
  int            idle_cycles = 0;
  logic [16:0]   bases_hit = '0;

  integer_to_base_digits u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),   // value
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),   // out_char
    .m_axis_tlast (m_axis_tlast)
  );

  always #6 clk = ~clk;

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Work out the characters one value turns into under the current settings
  task automatic queue_expected_text(input logic [VW-1:0] value);
    logic [VW-1:0]      magnitude;
    logic [VW-1:0]      radix;
    logic [DIGIT_W-1:0] remainders [MAXD];
    logic [DIGIT_W-1:0] d;
    int                 ndigits;
    text_char_t         c;
    if (base_setting < 2) radix = 2;
    else if (base_setting > MAX_BASE_DEF) radix = MAX_BASE_DEF;
    else radix = VW'(base_setting);
    bases_hit[radix] = 1'b1;
    // the unsigned negation also covers the most negative value
    magnitude = value[VW-1] ? -value : value;
    ndigits = 0;
    do begin
      remainders[ndigits] = DIGIT_W'(magnitude % radix);
      magnitude = magnitude / radix;
      ndigits++;
    end while (magnitude != 0 && ndigits < MAXD);
    if (value[VW-1]) begin
      c.ch = MINUS_CHAR;
      c.last = 1'b0;
      expected_chars.push_back(c);
    end
    for (int i = ndigits - 1; i >= 0; i--) begin
      d = remainders[i];
      c.ch = d[3] ? glyphs_high[int'(d[2:0]) * CHUNK_BITS +: CHAR_W]
                  : glyphs_low[int'(d[2:0]) * CHUNK_BITS +: CHAR_W];
      c.last = (i == 0);
      expected_chars.push_back(c);
    end
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [CHARS_W-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      REG_DIGIT_BASE:       base_setting = data[BASE_W-1:0];
      REG_DIGIT_CHARS_LOW:  glyphs_low = data;
      REG_DIGIT_CHARS_HIGH: glyphs_high = data;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_values.size() != 0 || offering || expected_chars.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  // Input side: offer queued values, hold each until the transaction completes
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      offering = 1'b0;
      send_gap = 0;
    end else begin
      if (offering && s_axis_tready) begin
        queue_expected_text(word_on_bus);
        values_sent++;
        offering = 1'b0;
        send_gap = send_idle_on ? pick_gap() : 0;
      end
      if (!offering) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_values.size() != 0) begin
          word_on_bus = pending_values.pop_front();
          offering = 1'b1;
        end
      end
      s_axis_tvalid <= offering;
      s_axis_tdata <= TDATA_W'(word_on_bus);
    end
  end

  // Output side: check each character, stall at random
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      stall_left = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        chars_checked++;
        if (expected_chars.size() == 0) begin
          stray_chars++;
          if (mismatches + stray_chars <= 10)
            $display("Unexpected character %h last %b", m_axis_tdata, m_axis_tlast);
        end else begin
          if (m_axis_tdata !== expected_chars[0].ch || m_axis_tlast !== expected_chars[0].last) begin
            mismatches++;
            if (mismatches + stray_chars <= 10)
              $display("Mismatch: got char %h last %b, expected char %h last %b",
                       m_axis_tdata, m_axis_tlast, expected_chars[0].ch, expected_chars[0].last);
          end
          void'(expected_chars.pop_front());
        end
      end
      if (long_hold_req > 0) begin
        stall_left = long_hold_req;
        long_hold_req = 0;
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (recv_idle_on && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  // Stop the run if no transaction of any kind happens for too long
  always @(posedge clk) begin
    if (rst || cfg_we || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles == STALL_LIMIT) begin
        $display("Timeout: no transaction for %0d cycles, %0d characters outstanding",
                 STALL_LIMIT, expected_chars.size());
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    logic [BASE_W-1:0] base_pick;
    logic [VW-1:0]     draw;
    int                leftover;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: base 10, default digit table
    @(negedge clk);
    pending_values.push_back(32'd0);
    pending_values.push_back(32'd1);
    pending_values.push_back(32'hFFFF_FFFF);
    pending_values.push_back(32'd9);
    pending_values.push_back(32'd10);
    pending_values.push_back(-32'd10);
    pending_values.push_back(32'h7FFF_FFFF);
    pending_values.push_back(32'h8000_0000);
    pending_values.push_back(32'h5555_5555);
    pending_values.push_back(32'hAAAA_AAAA);
    wait_drained();

    // Binary: longest texts
    write_register(REG_DIGIT_BASE, CHARS_W'(2));
    @(negedge clk);
    pending_values.push_back(32'd0);
    pending_values.push_back(32'h8000_0000);
    pending_values.push_back(32'hFFFF_FFFF);
    pending_values.push_back(32'h7FFF_FFFF);
    wait_drained();

    // Hex with a scrambled digit table
    write_register(REG_DIGIT_CHARS_LOW, {$urandom, $urandom});
    write_register(REG_DIGIT_CHARS_HIGH, {$urandom, $urandom});
    write_register(REG_DIGIT_BASE, CHARS_W'(16));
    @(negedge clk);
    pending_values.push_back(32'hFEDC_BA98);
    pending_values.push_back(32'h0123_4567);
    wait_drained();

    // Out-of-range bases clamp to 2 and to 16
    write_register(REG_DIGIT_BASE, CHARS_W'(0));
    @(negedge clk);
    pending_values.push_back(32'd5);
    wait_drained();
    write_register(REG_DIGIT_BASE, CHARS_W'(1));
    @(negedge clk);
    pending_values.push_back(-32'd6);
    wait_drained();
    write_register(REG_DIGIT_BASE, CHARS_W'(17));
    @(negedge clk);
    pending_values.push_back(32'hFFFF_FFFF);
    wait_drained();
    write_register(REG_DIGIT_BASE, CHARS_W'(31));
    @(negedge clk);
    pending_values.push_back(32'h8000_0000);
    wait_drained();

    // A write to an unmapped index must change nothing
    write_register(REG_UNUSED, {$urandom, $urandom});
    @(negedge clk);
    pending_values.push_back(32'd255);
    wait_drained();

    for (int phase = 0; phase < 10; phase++) begin
      if ($urandom_range(0, 3) == 0) base_pick = EXTREME_BASES[$urandom_range(0, 5)];
      else base_pick = BASE_W'($urandom_range(2, 16));
      write_register(REG_DIGIT_BASE, CHARS_W'(base_pick));
      if (phase == 0) begin
        write_register(REG_DIGIT_CHARS_LOW, CHARS_LOW_RESET);
        write_register(REG_DIGIT_CHARS_HIGH, CHARS_HIGH_RESET);
      end else if ($urandom_range(0, 1) == 1) begin
        write_register(REG_DIGIT_CHARS_LOW, {$urandom, $urandom});
        write_register(REG_DIGIT_CHARS_HIGH, {$urandom, $urandom});
      end
      @(negedge clk);
      // first phase: receiver holds off while the sender keeps offering; second: no idling
      send_idle_on = (phase >= 2) && ($urandom_range(0, 4) != 0);
      recv_idle_on = (phase != 1);
      if (phase == 0) long_hold_req = LONG_HOLD;
      repeat (40) begin
        case ($urandom_range(0, 5))
          0: draw = $urandom;
          1: draw = $urandom_range(0, 40);
          2: draw = -$urandom_range(1, 40);
          3: draw = 32'h8000_0000 + $urandom_range(0, 3);
          4: draw = 32'h7FFF_FFFF - $urandom_range(0, 3);
          default: begin
            draw = $urandom >> $urandom_range(0, 31);
            if ($urandom_range(0, 1) == 1) draw = -draw;
          end
        endcase
        pending_values.push_back(draw);
      end
      wait_drained();
    end

    // Catch any character arriving after the last expected one
    repeat (200) @(posedge clk);
    leftover = expected_chars.size();
    $display("Converted %0d values into %0d characters across %0d distinct effective bases,",
             values_sent, chars_checked, $countones(bases_hit));
    $display("including clamped bases, custom digit tables and a long output stall.");
    if (mismatches == 0 && stray_chars == 0 && leftover == 0) begin
      $display("== PASS ==");
    end else begin
      $display("Mismatches %0d, unexpected %0d, missing %0d", mismatches, stray_chars, leftover);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
`default_nettype wire
